// ===== rtl/core/fpsba_pkg.sv =====
// Shared constants, codes, types and helper functions of the page-state bitmap allocator.
package fpsba_pkg;

  localparam int MAX_WORDS_DEF   = 1024;
  localparam int PAGE_BYTES_DEF  = 256;
  localparam int BLOCK_BYTES_DEF = 4096;

  localparam int REQ_W      = 2;
  localparam int IDX_W      = 10;
  localparam int WORD_W     = 32;
  localparam int SLOTS      = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 15;
  localparam int CNTK_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int ADDR_W     = 25;
  localparam int FB_W       = 23;
  localparam int PTR_W      = 11;
  localparam int BASE_W     = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_POINTER = 2'd2;

  localparam logic [1:0] PS_DIRTY = 2'd0;
  localparam logic [1:0] PS_BAD   = 2'd1;
  localparam logic [1:0] PS_USED  = 2'd2;
  localparam logic [1:0] PS_FREE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NWORDS = 1'b1;

  localparam logic [CNT_W-1:0]  COUNT_MAX      = 15'h7FFF;
  localparam logic [FB_W-1:0]   FREE_BYTES_MAX = 23'h7FFFFF;
  localparam logic [PTR_W-1:0]  NWORDS_RESET   = 11'd1024;

  typedef struct packed {
    logic             start;
    logic [PTR_W-1:0] from;
    logic [PTR_W-1:0] limit;
    logic [1:0]       target;
  } scan_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              found;
    logic [PTR_W-1:0]  word;
    logic [SLOT_W-1:0] slot;
  } scan_res_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
  } rd_port_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } slot_hit_t;

  function automatic slot_hit_t find_slot(input logic [WORD_W-1:0] w, input logic [1:0] st);
    slot_hit_t r;
    r.found = 1'b0;
    r.slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (w[2*i +: 2] == st) begin
        r.found = 1'b1;
        r.slot  = SLOT_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [CNTK_W-1:0] count_state(input logic [WORD_W-1:0] w,
                                                    input logic [1:0] st);
    logic [CNTK_W-1:0] c;
    c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      c = c + CNTK_W'(w[2*i +: 2] == st);
    end
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [CNTK_W-1:0] k);
    logic [CNT_W:0] s;
    s = {1'b0, cnt} + (CNT_W+1)'(k);
    return (s > (CNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/fpsba_if.sv =====
// Channel interfaces of the allocator: configuration, request and result.
interface fpsba_cfg_if import fpsba_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface fpsba_req_if import fpsba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] word_value;
  modport source (output valid, req_type, word_index, word_value, input ready);
  modport sink (input valid, req_type, word_index, word_value, output ready);
endinterface

interface fpsba_rsp_if import fpsba_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   page_address;
  logic [IDX_W-1:0]    write_word_out;
  logic [SLOT_W-1:0]   write_slot_out;
  logic                pointer_valid;
  logic [CNT_W-1:0]    free_pages;
  logic [CNT_W-1:0]    used_pages;
  logic [CNT_W-1:0]    dirty_pages;
  logic [CNT_W-1:0]    bad_pages;
  logic [FB_W-1:0]     free_bytes;
  modport source (output valid, status, page_address, write_word_out, write_slot_out,
                  pointer_valid, free_pages, used_pages, dirty_pages, bad_pages,
                  free_bytes, input ready);
  modport sink (input valid, status, page_address, write_word_out, write_slot_out,
                pointer_valid, free_pages, used_pages, dirty_pages, bad_pages,
                free_bytes, output ready);
endinterface

// ===== rtl/core/fpsba_ram.sv =====
// Bitmap word memory with one write port and one registered read port.
module fpsba_ram import fpsba_pkg::*; #(
  parameter int MAX_WORDS = MAX_WORDS_DEF,
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [MAX_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fpsba_scan.sv =====
// Word-by-word bitmap scanner that finds the first slot holding a given page state.
module fpsba_scan import fpsba_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  scan_req_t         ctl,
  output scan_res_t         res,
  output rd_port_t          rd,
  input  logic [WORD_W-1:0] rd_data
);

  logic             busy;
  logic             pend;
  logic [PTR_W-1:0] addr;
  logic [PTR_W-1:0] limit;
  logic [PTR_W-1:0] pend_word;
  logic [1:0]       target;
  slot_hit_t        hit_info;
  logic             hit;
  logic             more;

  assign hit_info = find_slot(rd_data, target);
  assign hit      = busy && pend && hit_info.found;
  assign more     = addr < limit;

  assign rd.en   = busy && !hit && more;
  assign rd.addr = addr;

  assign res.busy  = busy;
  assign res.done  = busy && (hit || !more);
  assign res.found = hit;
  assign res.word  = pend_word;
  assign res.slot  = hit_info.slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      pend <= 1'b0;
    end else if (busy) begin
      pend <= rd.en;
      if (res.done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      addr   <= ctl.from;
      limit  <= ctl.limit;
      target <= ctl.target;
    end else if (rd.en) begin
      addr      <= addr + PTR_W'(1);
      pend_word <= addr;
    end
  end

endmodule

// ===== rtl/core/flash_page_state_bitmap_allocator.sv =====
// Top level of the flash page-state bitmap allocator: sequencer, counters and pointer.
//
//   channel  direction  carries
//   cfg      in         register index and write data (always ready)
//   req      in         req_type, word_index, word_value
//   rsp      out        status, page address, write pointer, state counters, free bytes
//
// A load, an unknown request or a refused allocate passes straight from idle to the done
// state, and the next request can be accepted once its result enters the output register.
// A start and a granted allocate walk the bitmap one word per cycle through the scan unit
// on the single RAM read port, over the words in use.
// Reset clears the counters, the pointer and the base register and sets the word count to
// 1024; the bitmap RAM is not cleared and holds garbage until each word is loaded.
// A result waits in the output register; the next request is accepted meanwhile and
// its own result waits until the previous one has been taken.
module flash_page_state_bitmap_allocator import fpsba_pkg::*; #(
  parameter int MAX_WORDS   = MAX_WORDS_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  fpsba_cfg_if.sink  cfg,
  fpsba_req_if.sink  req,
  fpsba_rsp_if.source rsp
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_USED = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_WRAP = 3'd3;
  localparam logic [2:0] S_ARD  = 3'd4;
  localparam logic [2:0] S_AMOD = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]          state;
  logic [BASE_W-1:0]   cfg_base;
  logic [PTR_W-1:0]    cfg_nwords;
  logic [PTR_W-1:0]    n_words;
  logic [PTR_W-1:0]    ptr_word;
  logic [SLOT_W-1:0]   ptr_slot;
  logic                ptr_valid;
  logic [CNT_W-1:0]    cnt [4];
  logic [CNT_W-1:0]    cnt_load [4];
  logic [CNT_W-1:0]    cnt_dec [4];
  logic [CNT_W-1:0]    cnt_alloc [4];
  logic [REQ_W-1:0]    req_type_r;
  logic [STATUS_W-1:0] status_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                out_valid;
  logic                out_load;
  logic                acc;

  scan_req_t           scan_ctl;
  scan_res_t           scan_res;
  rd_port_t            scan_rd;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic [1:0]          page_state;
  logic [WORD_W-1:0]   alloc_word;
  logic [31:0]         page_addr_full;
  logic [31:0]         fb_full;
  logic [FB_W-1:0]     free_bytes_sat;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    if (32'(cfg_nwords) > 32'(MAX_WORDS)) begin
      n_words = PTR_W'(MAX_WORDS);
    end else if (cfg_nwords == '0) begin
      n_words = PTR_W'(1);
    end else begin
      n_words = cfg_nwords;
    end
  end

  assign page_state = ram_rdata[{ptr_slot, 1'b0} +: 2];
  assign alloc_word = (ram_rdata & ~(WORD_W'(3) << {ptr_slot, 1'b0}))
                    | (WORD_W'(PS_USED) << {ptr_slot, 1'b0});

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_load[i]  = sat_add(cnt[i], count_state(req.word_value, 2'(i)));
      cnt_dec[i]   = (2'(i) == page_state && cnt[i] != '0) ? cnt[i] - CNT_W'(1) : cnt[i];
      cnt_alloc[i] = (2'(i) == PS_USED) ? sat_add(cnt_dec[i], CNTK_W'(1)) : cnt_dec[i];
    end
  end

  assign page_addr_full = (32'(cfg_base) + 32'(ptr_word)) * 32'(BLOCK_BYTES)
                        + 32'(ptr_slot) * 32'(PAGE_BYTES);
  assign fb_full        = 32'(cnt[PS_FREE]) * 32'(PAGE_BYTES);
  assign free_bytes_sat = (fb_full > 32'(FREE_BYTES_MAX)) ? FREE_BYTES_MAX : FB_W'(fb_full);

  always_comb begin
    scan_ctl.start  = 1'b0;
    scan_ctl.from   = '0;
    scan_ctl.limit  = n_words;
    scan_ctl.target = PS_FREE;
    case (state)
      S_IDLE: begin
        if (acc && req.req_type == REQ_START) begin
          scan_ctl.start  = 1'b1;
          scan_ctl.target = PS_USED;
        end
      end
      S_USED: begin
        if (scan_res.done) begin
          scan_ctl.start = 1'b1;
          scan_ctl.from  = scan_res.found ? scan_res.word : '0;
        end
      end
      S_AMOD: begin
        scan_ctl.start = 1'b1;
        scan_ctl.from  = ptr_word;
      end
      S_FREE: begin
        if (scan_res.done && !scan_res.found && req_type_r == REQ_ALLOC) begin
          scan_ctl.start = 1'b1;
        end
      end
      default: begin
        scan_ctl.start = 1'b0;
      end
    endcase
  end

  assign ram_we    = (acc && req.req_type == REQ_LOAD && 32'(req.word_index) < 32'(MAX_WORDS))
                   || (state == S_AMOD);
  assign ram_waddr = (state == S_AMOD) ? AW'(ptr_word) : AW'(req.word_index);
  assign ram_wdata = (state == S_AMOD) ? alloc_word : req.word_value;
  assign ram_re    = scan_rd.en || (state == S_ARD);
  assign ram_raddr = (state == S_ARD) ? AW'(ptr_word) : AW'(scan_rd.addr);

  fpsba_ram #(
    .MAX_WORDS(MAX_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpsba_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .res     (scan_res),
    .rd      (scan_rd),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cfg_base   <= '0;
      cfg_nwords <= NWORDS_RESET;
      ptr_word   <= '0;
      ptr_slot   <= '0;
      ptr_valid  <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_BASE:   cfg_base   <= cfg.data[BASE_W-1:0];
          CFG_NWORDS: cfg_nwords <= cfg.data[PTR_W-1:0];
          default:    cfg_base   <= cfg_base;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            req_type_r <= req.req_type;
            status_r   <= STATUS_OK;
            addr_r     <= '0;
            case (req.req_type)
              REQ_LOAD: begin
                for (int i = 0; i < 4; i++) begin
                  cnt[i] <= cnt_load[i];
                end
                state <= S_DONE;
              end
              REQ_START: begin
                state <= S_USED;
              end
              REQ_ALLOC: begin
                if (cnt[PS_FREE] == '0) begin
                  status_r <= STATUS_NO_SPACE;
                  state    <= S_DONE;
                end else if (!ptr_valid) begin
                  status_r <= STATUS_NO_POINTER;
                  state    <= S_DONE;
                end else begin
                  state <= S_ARD;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_USED: begin
          if (scan_res.done) begin
            state <= S_FREE;
          end
        end
        S_ARD: begin
          state <= S_AMOD;
        end
        S_AMOD: begin
          for (int i = 0; i < 4; i++) begin
            cnt[i] <= cnt_alloc[i];
          end
          addr_r <= ADDR_W'(page_addr_full);
          state  <= S_FREE;
        end
        S_FREE: begin
          if (scan_res.done) begin
            if (scan_res.found) begin
              ptr_word  <= scan_res.word;
              ptr_slot  <= scan_res.slot;
              ptr_valid <= 1'b1;
              state     <= S_DONE;
            end else if (req_type_r == REQ_ALLOC) begin
              state <= S_WRAP;
            end else begin
              ptr_word  <= '0;
              ptr_slot  <= '0;
              ptr_valid <= 1'b0;
              status_r  <= STATUS_NO_SPACE;
              state     <= S_DONE;
            end
          end
        end
        S_WRAP: begin
          if (scan_res.done) begin
            if (scan_res.found) begin
              ptr_word  <= scan_res.word;
              ptr_slot  <= scan_res.slot;
              ptr_valid <= 1'b1;
            end else begin
              ptr_word  <= '0;
              ptr_slot  <= '0;
              ptr_valid <= 1'b0;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status         <= status_r;
      rsp.page_address   <= addr_r;
      rsp.write_word_out <= ptr_word[IDX_W-1:0];
      rsp.write_slot_out <= ptr_slot;
      rsp.pointer_valid  <= ptr_valid;
      rsp.free_pages     <= cnt[PS_FREE];
      rsp.used_pages     <= cnt[PS_USED];
      rsp.dirty_pages    <= cnt[PS_DIRTY];
      rsp.bad_pages      <= cnt[PS_BAD];
      rsp.free_bytes     <= free_bytes_sat;
    end
  end

  a_ptr_cleared: assert property (@(posedge clk) disable iff (rst)
    !ptr_valid |-> (ptr_word == '0 && ptr_slot == '0))
    else $error("Write pointer not cleared while invalid.");

  a_scan_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !scan_res.busy)
    else $error("Scan unit running while the sequencer is idle.");

  a_read_port: assert property (@(posedge clk) disable iff (rst)
    (state == S_ARD) |-> !scan_rd.en)
    else $error("Pointer word read collides with a scan read.");

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_AMOD) |=> (cnt[PS_USED] != '0))
    else $error("Used page count is zero after an allocation.");

endmodule

// ===== bench/fpsba_checker.sv =====
// Checker for the page-state bitmap allocator: predicts every result and compares it.
module fpsba_checker import fpsba_pkg::*; (
  input  logic clk,
  input  logic rst,
  fpsba_cfg_if cfg,
  fpsba_req_if req,
  fpsba_rsp_if rsp,
  output int   errors,
  output int   outstanding,
  output int   granted,
  output int   no_space,
  output int   no_pointer
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_address;
    logic [IDX_W-1:0]    write_word_out;
    logic [SLOT_W-1:0]   write_slot_out;
    logic                pointer_valid;
    logic [CNT_W-1:0]    free_pages;
    logic [CNT_W-1:0]    used_pages;
    logic [CNT_W-1:0]    dirty_pages;
    logic [CNT_W-1:0]    bad_pages;
    logic [FB_W-1:0]     free_bytes;
  } page_result_t;

  logic [WORD_W-1:0] bitmap [MAX_WORDS_DEF];
  logic [IDX_W-1:0]  ptr_word;
  logic [SLOT_W-1:0] ptr_slot;
  logic              ptr_valid;
  logic [CNT_W-1:0]  tally [4];
  logic [BASE_W-1:0] base_block;
  logic [PTR_W-1:0]  nwords;
  page_result_t      expected_results [$];

  function automatic int first_slot_in(input logic [WORD_W-1:0] w, input logic [1:0] st);
    for (int i = 0; i < SLOTS; i++) begin
      if (w[2*i +: 2] == st) return i;
    end
    return -1;
  endfunction

  function automatic int words_live();
    int n;
    n = int'(nwords);
    if (n > MAX_WORDS_DEF) n = MAX_WORDS_DEF;
    if (n == 0) n = 1;
    return n;
  endfunction

  function automatic void count_in(input logic [1:0] st);
    if (tally[st] < COUNT_MAX) tally[st] = tally[st] + 1'b1;
  endfunction

  function automatic void count_out(input logic [1:0] st);
    if (tally[st] != '0) tally[st] = tally[st] - 1'b1;
  endfunction

  function automatic bit place_pointer(input int start_word, input int n);
    int s;
    for (int w = start_word; w < n; w++) begin
      s = first_slot_in(bitmap[w], PS_FREE);
      if (s >= 0) begin
        ptr_word  = IDX_W'(w);
        ptr_slot  = SLOT_W'(s);
        ptr_valid = 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void clear_pointer();
    ptr_word  = '0;
    ptr_slot  = '0;
    ptr_valid = 1'b0;
  endfunction

  function automatic page_result_t serve_request(input logic [REQ_W-1:0] kind,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [WORD_W-1:0] val);
    page_result_t      r;
    int                n;
    int                scan_from;
    logic [WORD_W-1:0] w;
    logic [1:0]        old;
    longint unsigned   addr;
    longint unsigned   bytes;
    r = '0;
    n = words_live();
    case (kind)
      REQ_LOAD: begin
        bitmap[idx] = val;
        for (int i = 0; i < SLOTS; i++) count_in(val[2*i +: 2]);
      end
      REQ_START: begin
        scan_from = 0;
        for (int k = 0; k < n; k++) begin
          if (first_slot_in(bitmap[k], PS_USED) >= 0) begin
            scan_from = k;
            break;
          end
        end
        if (!place_pointer(scan_from, n)) begin
          clear_pointer();
          r.status = STATUS_NO_SPACE;
        end
      end
      REQ_ALLOC: begin
        if (tally[PS_FREE] == '0) begin
          r.status = STATUS_NO_SPACE;
          no_space++;
        end else if (!ptr_valid) begin
          r.status = STATUS_NO_POINTER;
          no_pointer++;
        end else begin
          granted++;
          w    = bitmap[ptr_word];
          old  = w[2*ptr_slot +: 2];
          addr = (longint'(base_block) + longint'(ptr_word)) * BLOCK_BYTES_DEF
                 + longint'(ptr_slot) * PAGE_BYTES_DEF;
          r.page_address = ADDR_W'(addr);
          w[2*ptr_slot +: 2] = PS_USED;
          bitmap[ptr_word] = w;
          count_out(old);
          count_in(PS_USED);
          if (!place_pointer(int'(ptr_word), n) && !place_pointer(0, n)) clear_pointer();
        end
      end
      default: ;
    endcase
    bytes = longint'(tally[PS_FREE]) * PAGE_BYTES_DEF;
    if (bytes > FREE_BYTES_MAX) bytes = FREE_BYTES_MAX;
    r.write_word_out = ptr_word;
    r.write_slot_out = ptr_slot;
    r.pointer_valid  = ptr_valid;
    r.free_pages     = tally[PS_FREE];
    r.used_pages     = tally[PS_USED];
    r.dirty_pages    = tally[PS_DIRTY];
    r.bad_pages      = tally[PS_BAD];
    r.free_bytes     = FB_W'(bytes);
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    page_result_t want;
    if (rst) begin
      clear_pointer();
      for (int i = 0; i < 4; i++) tally[i] = '0;
      base_block = '0;
      nwords     = NWORDS_RESET;
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request waiting");
          errors++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 64'(want.status), 64'(rsp.status));
          compare_field("page_address", 64'(want.page_address), 64'(rsp.page_address));
          compare_field("write_word_out", 64'(want.write_word_out),
                        64'(rsp.write_word_out));
          compare_field("write_slot_out", 64'(want.write_slot_out),
                        64'(rsp.write_slot_out));
          compare_field("pointer_valid", 64'(want.pointer_valid), 64'(rsp.pointer_valid));
          compare_field("free_pages", 64'(want.free_pages), 64'(rsp.free_pages));
          compare_field("used_pages", 64'(want.used_pages), 64'(rsp.used_pages));
          compare_field("dirty_pages", 64'(want.dirty_pages), 64'(rsp.dirty_pages));
          compare_field("bad_pages", 64'(want.bad_pages), 64'(rsp.bad_pages));
          compare_field("free_bytes", 64'(want.free_bytes), 64'(rsp.free_bytes));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_BASE:   base_block = cfg.data[BASE_W-1:0];
          CFG_NWORDS: nwords     = cfg.data[PTR_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(serve_request(req.req_type, req.word_index, req.word_value));
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the allocator testbench: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
  import fpsba_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 2 * MAX_WORDS_DEF + 16;
  localparam int CONFIG_GAP   = 8;
  localparam int FINAL_WAIT   = 50000;

  logic clk;
  logic rst;

  fpsba_cfg_if cfg_ch();
  fpsba_req_if req_ch();
  fpsba_rsp_if rsp_ch();

  int errors, outstanding, granted, no_space, no_pointer;
  int send_idle_pct, stall_pct;
  int hold_len, hold_seq;
  int live_words;
  int n_load, n_start, n_alloc, n_other, n_settings;

  flash_page_state_bitmap_allocator DUT (
    .clk,
    .rst,
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  fpsba_checker page_checker (
    .clk,
    .rst,
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch),
    .errors,
    .outstanding,
    .granted,
    .no_space,
    .no_pointer
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [WORD_W-1:0] random_word(input int free_pct);
    logic [WORD_W-1:0] w;
    if ($urandom_range(9) == 0) return $urandom;
    for (int i = 0; i < SLOTS; i++) begin
      if ($urandom_range(99) < free_pct) w[2*i +: 2] = PS_FREE;
      else w[2*i +: 2] = 2'($urandom_range(2));
    end
    return w;
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
                              input logic [WORD_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.word_index <= idx;
    req_ch.word_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    case (kind)
      REQ_LOAD:  n_load++;
      REQ_START: n_start++;
      REQ_ALLOC: n_alloc++;
      default:   n_other++;
    endcase
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic reconfigure(input int base, input int nw);
    settle();
    repeat (CONFIG_GAP) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_BASE;
    cfg_ch.data  <= CFG_DATA_W'(base);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_NWORDS;
    cfg_ch.data  <= CFG_DATA_W'(nw);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    live_words = (nw == 0) ? 1 : (nw > MAX_WORDS_DEF) ? MAX_WORDS_DEF : nw;
    n_settings++;
  endtask

  task automatic fill_bitmap(input int free_pct);
    for (int i = 0; i < live_words; i++) begin
      send_request(REQ_LOAD, IDX_W'(i), random_word(free_pct));
    end
  endtask

  task automatic random_round(input int count, input bit squeeze);
    int pick;
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < count; i++) begin
      if (squeeze && i == count / 2) begin
        hold_len = 300;
        hold_seq++;
      end
      if (squeeze && i == 3 * count / 4) settle();
      pick = $urandom_range(99);
      if (pick < 30) begin
        if ($urandom_range(4) == 0) idx = IDX_W'($urandom_range(MAX_WORDS_DEF - 1));
        else idx = IDX_W'($urandom_range(live_words - 1));
        send_request(REQ_LOAD, idx, random_word($urandom_range(70)));
      end else if (pick < 45) begin
        send_request(REQ_START, IDX_W'($urandom), $urandom);
      end else if (pick < 95) begin
        send_request(REQ_ALLOC, IDX_W'($urandom), $urandom);
      end else begin
        send_request(REQ_UNUSED, IDX_W'($urandom), $urandom);
      end
    end
  endtask

  initial begin : stimulus
    int idle_modes [4];
    int stall_modes [4];
    int base;
    int nw;
    int waited;
    idle_modes  = '{0, 63, 0, 21};
    stall_modes = '{0, 0, 63, 21};
    rst               <= 1'b1;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_BASE;
    cfg_ch.data       <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_LOAD;
    req_ch.word_index <= '0;
    req_ch.word_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_UNUSED, '1, '1);
    reconfigure(4095, 4);
    send_request(REQ_LOAD, 10'd0, 32'hAAAAAAAA);
    send_request(REQ_LOAD, 10'd1, 32'h00000000);
    send_request(REQ_LOAD, 10'd2, 32'h55555555);
    send_request(REQ_LOAD, 10'd3, 32'hAAAAAAAA);
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_START, '0, '0);
    send_request(REQ_LOAD, 10'd3, 32'hFFFFFFFF);
    send_request(REQ_ALLOC, '1, '1);
    send_request(REQ_START, '1, '1);
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_LOAD, 10'd3, 32'hFFFFFFF3);
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_LOAD, 10'd1023, 32'h55555555);
    reconfigure(0, 0);
    send_request(REQ_LOAD, 10'd0, 32'hAAAAAAAB);
    send_request(REQ_START, '0, '0);
    send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_ALLOC, '0, '0);

    reconfigure($urandom_range(4095), 2047);
    send_request(REQ_LOAD, 10'd0, 32'h000000FE);
    send_request(REQ_LOAD, 10'd1, 32'hC0000000);
    send_request(REQ_LOAD, 10'd2, 32'hFFFFFFFF);
    send_request(REQ_START, '0, '0);
    repeat (3) send_request(REQ_ALLOC, '0, '0);
    send_request(REQ_START, '0, '0);
    send_request(REQ_ALLOC, '0, '0);

    for (int m = 0; m < 4; m++) begin
      send_idle_pct = idle_modes[m];
      stall_pct     = stall_modes[m];
      for (int rnd = 0; rnd < 3; rnd++) begin
        base = (rnd == 0) ? 0 : (rnd == 1) ? 4095 : $urandom_range(4095);
        nw   = (m == 0 && rnd == 0) ? 1 : (m == 3 && rnd == 2) ? 16 : $urandom_range(2, 16);
        reconfigure(base, nw);
        fill_bitmap($urandom_range(5, 60));
        random_round(25, rnd == 0);
      end
    end

    req_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < FINAL_WAIT);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads, %0d starts, %0d allocates and %0d requests of unknown type",
             n_load, n_start, n_alloc, n_other);
    $display("under %0d register settings: %0d allocates granted, %0d without space, %0d %s",
             n_settings, granted, no_space, no_pointer, "without a located pointer.");
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== flash_page_state_bitmap_allocator.f =====
rtl/core/fpsba_pkg.sv
rtl/core/fpsba_if.sv
rtl/core/fpsba_ram.sv
rtl/core/fpsba_scan.sv
rtl/core/flash_page_state_bitmap_allocator.sv
bench/fpsba_checker.sv
bench/tb_top.sv
